[rtl/core/gscr_pkg.sv]
// shared types, constants and field layout for the gaze change record encoder
package gscr_pkg;

   // port widths
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // default depth of the record queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // reset values of the code registers
   localparam logic [7:0] PAUSE_RESET   = 8'h00;
   localparam logic [7:0] BLINK_RESET   = 8'h01;
   localparam logic [7:0] ERROR_RESET   = 8'h20;
   localparam logic [7:0] TIMEOUT_RESET = 8'h40;

   // status byte bits built from the raw status
   localparam logic [7:0] STAT_SACCADE = 8'h02;
   localparam logic [7:0] STAT_UNSAFE  = 8'h10;
   localparam logic [7:0] STAT_NOLOCK  = 8'h04;

   // byte closing a trial
   localparam logic [7:0] END_BYTE = 8'h00;

   // duration length codes (code byte bits 7:6)
   localparam logic [1:0] DLEN_NONE = 2'd0;
   localparam logic [1:0] DLEN_ONE  = 2'd1;
   localparam logic [1:0] DLEN_TWO  = 2'd2;
   localparam logic [1:0] DLEN_FOUR = 2'd3;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAUSE   = 2'd0,
      CSR_BLINK   = 2'd1,
      CSR_ERROR   = 2'd2,
      CSR_TIMEOUT = 2'd3
   } csr_index_type;

   // byte positions of one record
   typedef enum logic [3:0] {
      STEP_CODE,
      STEP_DT0,
      STEP_DT1,
      STEP_DT2,
      STEP_DT3,
      STEP_XHI,
      STEP_XLO,
      STEP_YHI,
      STEP_YLO,
      STEP_STAT,
      STEP_FLAG,
      STEP_END,
      STEP_DONE
   } step_type;

   // one record handed from front to back
   typedef struct packed {
      logic [3:0]  mask;     // bit0 x, bit1 y, bit2 status, bit3 flags
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [7:0]  status;
      logic [7:0]  flags;
      logic [31:0] dt;
      logic [1:0]  dlen;
      logic        add_end;  // end byte follows the record
      logic        eob;      // record closes the burst of its sample
   } rec_type;

   // duration length code from the signed duration
   function automatic logic [1:0] dur_len(input logic [31:0] dt);
      logic [1:0] len;
      if (dt[31]) begin
         len = DLEN_NONE;
      end else if (dt[31:8] == 24'd0) begin
         len = DLEN_ONE;
      end else if (dt[31:16] == 16'd0) begin
         len = DLEN_TWO;
      end else begin
         len = DLEN_FOUR;
      end
      return len;
   endfunction

endpackage

[rtl/core/gscr_front.sv]
// front end: code registers, sample classification, run state and record issue
module gscr_front (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [gscr_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tlast,
   // configuration channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gscr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gscr_pkg::CSR_DATA_W-1:0]      csr_data,
   // record queue write side
   output logic                                 push,
   output gscr_pkg::rec_type                    push_rec,
   input  logic                                 queue_full
);

   // code registers
   logic [7:0] pause_ff, blink_ff, error_ff, timeout_ff;

   // run state
   logic        seen_ff;
   logic [15:0] run_x_ff, run_y_ff;
   logic [7:0]  run_st_ff, run_fl_ff;
   logic [3:0]  run_mask_ff;
   logic [31:0] base_ff, prev_ff, prev_p2_ff;

   // second record of a sample that changes state and ends the trial
   logic              pend_valid_ff, pend_valid_in;
   gscr_pkg::rec_type pend_ff, pend_in;

   // unpacked sample fields
   logic [15:0] s_x, s_y;
   logic [5:0]  s_raw;
   logic        s_stim;
   logic [1:0]  s_user, s_key;
   logic [31:0] s_stamp;
   logic        accept;

   // classification
   logic [7:0]  st_new, fl_new;
   logic [3:0]  chg;
   logic        fin_emit;
   logic [31:0] base_new, dt_a, dt_b;
   gscr_pkg::rec_type rec_a, rec_b;

   assign s_x     = req_tdata[15:0];
   assign s_y     = req_tdata[31:16];
   assign s_raw   = req_tdata[37:32];
   assign s_stim  = req_tdata[38];
   assign s_user  = req_tdata[40:39];
   assign s_key   = req_tdata[42:41];
   assign s_stamp = req_tdata[74:43];

   assign csr_ready  = 1'b1;
   assign req_tready = !pend_valid_ff && !queue_full;
   assign accept     = req_tvalid && req_tready;

   // code register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pause_ff   <= gscr_pkg::PAUSE_RESET;
         blink_ff   <= gscr_pkg::BLINK_RESET;
         error_ff   <= gscr_pkg::ERROR_RESET;
         timeout_ff <= gscr_pkg::TIMEOUT_RESET;
      end else if (csr_valid) begin
         unique case (gscr_pkg::csr_index_type'(csr_index))
            gscr_pkg::CSR_PAUSE:   pause_ff   <= csr_data;
            gscr_pkg::CSR_BLINK:   blink_ff   <= csr_data;
            gscr_pkg::CSR_ERROR:   error_ff   <= csr_data;
            gscr_pkg::CSR_TIMEOUT: timeout_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // status byte, earlier conditions win
   always_comb begin
      priority if (!s_raw[5]) begin
         st_new = timeout_ff;
      end else if (!s_raw[4]) begin
         st_new = error_ff;
      end else if (s_raw[3]) begin
         st_new = blink_ff;
      end else begin
         st_new = (s_raw[0] ? gscr_pkg::STAT_SACCADE : 8'h00)
                | (!s_raw[1] ? gscr_pkg::STAT_UNSAFE : 8'h00)
                | (!s_raw[2] ? gscr_pkg::STAT_NOLOCK : 8'h00);
      end
   end

   // flags byte
   assign fl_new = {s_key[1], s_key[0], s_user[1], s_user[0], s_stim, 3'b000};

   // change detection and durations
   assign chg = {fl_new != run_fl_ff, st_new != run_st_ff,
                 s_y != run_y_ff, s_x != run_x_ff};
   assign fin_emit = req_tlast && ((|chg ? st_new : run_st_ff) != pause_ff);
   assign base_new = (|chg) ? prev_p2_ff : base_ff;
   assign dt_a     = prev_ff - base_ff;
   assign dt_b     = s_stamp - base_new;

   // record closing the current run
   always_comb begin
      rec_a.mask    = run_mask_ff;
      rec_a.pos_x   = run_x_ff;
      rec_a.pos_y   = run_y_ff;
      rec_a.status  = run_st_ff;
      rec_a.flags   = run_fl_ff;
      rec_a.dt      = dt_a;
      rec_a.dlen    = gscr_pkg::dur_len(dt_a);
      rec_a.add_end = 1'b0;
      rec_a.eob     = !fin_emit;
   end

   // record closing the final run; its fields equal the sample's
   always_comb begin
      rec_b.mask    = (|chg) ? chg : run_mask_ff;
      rec_b.pos_x   = s_x;
      rec_b.pos_y   = s_y;
      rec_b.status  = st_new;
      rec_b.flags   = fl_new;
      rec_b.dt      = dt_b;
      rec_b.dlen    = gscr_pkg::dur_len(dt_b);
      rec_b.add_end = 1'b1;
      rec_b.eob     = 1'b1;
   end

   // record issue into the queue
   always_comb begin
      push          = 1'b0;
      push_rec      = rec_a;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (pend_valid_ff) begin
         if (!queue_full) begin
            push          = 1'b1;
            push_rec      = pend_ff;
            pend_valid_in = 1'b0;
         end
      end else if (accept && seen_ff) begin
         if (|chg) begin
            push     = 1'b1;
            push_rec = rec_a;
            if (fin_emit) begin
               pend_valid_in = 1'b1;
               pend_in       = rec_b;
            end
         end else if (fin_emit) begin
            push     = 1'b1;
            push_rec = rec_b;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         seen_ff       <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         if (accept) begin
            seen_ff <= !req_tlast;
         end
      end
   end

   // run payload
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (accept) begin
         prev_ff    <= s_stamp;
         prev_p2_ff <= s_stamp + 32'd2;
         if (!seen_ff) begin
            run_x_ff    <= s_x;
            run_y_ff    <= s_y;
            run_st_ff   <= pause_ff;
            run_fl_ff   <= 8'h00;
            run_mask_ff <= {1'b0, 1'b1, s_y != 16'd0, s_x != 16'd0};
            base_ff     <= s_stamp + 32'd1;
         end else if (|chg) begin
            run_x_ff    <= s_x;
            run_y_ff    <= s_y;
            run_st_ff   <= st_new;
            run_fl_ff   <= fl_new;
            run_mask_ff <= chg;
            base_ff     <= prev_p2_ff;
         end
      end
   end

endmodule

[rtl/core/gscr_queue.sv]
// short record queue between front and back
module gscr_queue #(
   parameter int Depth = gscr_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gscr_pkg::rec_type push_rec,
   output logic              full,
   input  logic              pop,
   output gscr_pkg::rec_type head,
   output logic              nonempty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   gscr_pkg::rec_type slot_ff [Depth];
   logic [PtrW-1:0] wr_ff, rd_ff;
   logic [CntW-1:0] cnt_ff;
   logic            do_push, do_pop;

   assign full     = (cnt_ff == FullCnt);
   assign nonempty = (cnt_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;
   assign head     = slot_ff[rd_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == LastPtr) ? '0 : wr_ff + PtrW'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == LastPtr) ? '0 : rd_ff + PtrW'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CntW'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CntW'(1);
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_rec;
      end
   end

endmodule

[rtl/core/gscr_back.sv]
// back end: walks a record byte by byte into the output register
module gscr_back (
   input  logic                              clock,
   input  logic                              reset,
   // record queue read side
   input  gscr_pkg::rec_type                 head,
   input  logic                              nonempty,
   output logic                              pop,
   // byte channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gscr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   gscr_pkg::rec_type  cur_ff, cur_in;
   gscr_pkg::step_type step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_data_ff, out_data_in;
   logic               out_last_ff, out_last_in;

   logic               slot_free;
   logic [7:0]         cur_byte;
   gscr_pkg::step_type nxt, after_dt, after_x, after_y, after_st, after_fl;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign slot_free  = !out_valid_ff || rsp_tready;

   // successor steps, skipping fields that did not change
   always_comb begin
      after_fl = cur_ff.add_end ? gscr_pkg::STEP_END : gscr_pkg::STEP_DONE;
      after_st = cur_ff.mask[3] ? gscr_pkg::STEP_FLAG : after_fl;
      after_y  = cur_ff.mask[2] ? gscr_pkg::STEP_STAT : after_st;
      after_x  = cur_ff.mask[1] ? gscr_pkg::STEP_YHI  : after_y;
      after_dt = cur_ff.mask[0] ? gscr_pkg::STEP_XHI  : after_x;
   end

   // byte of the current step and the step after it
   always_comb begin
      unique case (step_ff)
         gscr_pkg::STEP_CODE: begin
            cur_byte = {cur_ff.dlen, cur_ff.mask[3], cur_ff.mask[2], 2'b00,
                        cur_ff.mask[1], cur_ff.mask[0]};
            nxt = (cur_ff.dlen != gscr_pkg::DLEN_NONE) ? gscr_pkg::STEP_DT0 : after_dt;
         end
         gscr_pkg::STEP_DT0: begin
            cur_byte = cur_ff.dt[7:0];
            nxt = (cur_ff.dlen == gscr_pkg::DLEN_TWO || cur_ff.dlen == gscr_pkg::DLEN_FOUR)
                ? gscr_pkg::STEP_DT1 : after_dt;
         end
         gscr_pkg::STEP_DT1: begin
            cur_byte = cur_ff.dt[15:8];
            nxt = (cur_ff.dlen == gscr_pkg::DLEN_FOUR) ? gscr_pkg::STEP_DT2 : after_dt;
         end
         gscr_pkg::STEP_DT2: begin
            cur_byte = cur_ff.dt[23:16];
            nxt      = gscr_pkg::STEP_DT3;
         end
         gscr_pkg::STEP_DT3: begin
            cur_byte = cur_ff.dt[31:24];
            nxt      = after_dt;
         end
         gscr_pkg::STEP_XHI: begin
            cur_byte = cur_ff.pos_x[15:8];
            nxt      = gscr_pkg::STEP_XLO;
         end
         gscr_pkg::STEP_XLO: begin
            cur_byte = cur_ff.pos_x[7:0];
            nxt      = after_x;
         end
         gscr_pkg::STEP_YHI: begin
            cur_byte = cur_ff.pos_y[15:8];
            nxt      = gscr_pkg::STEP_YLO;
         end
         gscr_pkg::STEP_YLO: begin
            cur_byte = cur_ff.pos_y[7:0];
            nxt      = after_y;
         end
         gscr_pkg::STEP_STAT: begin
            cur_byte = cur_ff.status;
            nxt      = after_st;
         end
         gscr_pkg::STEP_FLAG: begin
            cur_byte = cur_ff.flags;
            nxt      = after_fl;
         end
         gscr_pkg::STEP_END: begin
            cur_byte = gscr_pkg::END_BYTE;
            nxt      = gscr_pkg::STEP_DONE;
         end
         default: begin
            cur_byte = gscr_pkg::END_BYTE;
            nxt      = gscr_pkg::STEP_DONE;
         end
      endcase
   end

   // sequencer: load a record, then one byte per free output slot
   always_comb begin
      pop          = 1'b0;
      cur_in       = cur_ff;
      step_in      = step_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (!busy_ff) begin
         if (nonempty) begin
            pop     = 1'b1;
            cur_in  = head;
            step_in = gscr_pkg::STEP_CODE;
            busy_in = 1'b1;
         end
      end else if (slot_free) begin
         out_valid_in = 1'b1;
         out_data_in  = cur_byte;
         out_last_in  = cur_ff.eob && (nxt == gscr_pkg::STEP_DONE);
         step_in      = nxt;
         busy_in      = (nxt != gscr_pkg::STEP_DONE);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         step_ff      <= gscr_pkg::STEP_DONE;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

endmodule

[rtl/core/gaze_sample_change_record_encoder.sv]
// top level of the gaze sample change record encoder
//
// Samples enter on the req_ channel, one word per sample, tlast marking the
// final sample of a trial. Encoded bytes leave on the rsp_ channel, one byte
// per word, tlast high on the last byte that a sample causes. Code registers
// are written on the csr_ channel, which is always ready.
// A sample that ends a run writes one record into a short queue; the back end
// turns each record into its bytes. The record enters the queue when the
// sample is accepted; the back end loads it from the queue into its current
// record register, then registers its bytes in the output register, one byte
// per cycle while the receiver takes them. A final sample that also ends a run
// issues two records, and req_tready stays low until the second is queued. The
// queue depth sets how many records may wait before req_tready drops.
// Reset clears the run state, empties the queue and output register and puts
// the code registers at their defaults; no bytes are shown after reset. When
// the receiver stalls, the output byte holds and the queue fills, then the
// sample channel stalls.
module gaze_sample_change_record_encoder #(
   parameter int QueueDepth = gscr_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x, pos_y, raw_status, stim_flag, user_flags, key_flags, stamp, 5 zero bits
   input  logic [gscr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,  // last_sample
   // byte output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_byte
   output logic [gscr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,  // end_of_burst
   // code register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gscr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gscr_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic              push, queue_full, pop, nonempty;
   gscr_pkg::rec_type push_rec, head;

   // classification and run tracking
   gscr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push       (push),
      .push_rec   (push_rec),
      .queue_full (queue_full)
   );

   // record queue
   gscr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .full     (queue_full),
      .pop      (pop),
      .head     (head),
      .nonempty (nonempty)
   );

   // byte serializer
   gscr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .nonempty   (nonempty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/core/gscr_checker.sv]
// port checks for the gaze sample change record encoder, bound to the top level
module gscr_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [gscr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [gscr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              rsp_tlast,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [gscr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gscr_pkg::CSR_DATA_W-1:0]   csr_data
);

   // a stalled byte holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output word changed");

   // nothing is shown right after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

   // an empty block takes samples right after reset
   a_req_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("sample channel not ready after reset");

   // code register writes never stall
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind gaze_sample_change_record_encoder gscr_checker u_gscr_checker (.*);

[tb/tb_gaze_sample_change_record_encoder.sv]
// self-checking testbench for the gaze sample change record encoder
`timescale 1ns / 100ps

module tb_gaze_sample_change_record_encoder;

   localparam int STALL_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int TAIL_CYCLES    = 30;
   localparam int RANDOM_SAMPLES = 210;

   // change mask bits of a run
   localparam logic [3:0] CHG_X    = 4'b0001;
   localparam logic [3:0] CHG_Y    = 4'b0010;
   localparam logic [3:0] CHG_STAT = 4'b0100;
   localparam logic [3:0] CHG_FLAG = 4'b1000;

   // raw status bit positions
   localparam int RAW_SACCADE = 0;
   localparam int RAW_SAFE    = 1;
   localparam int RAW_LOCK    = 2;
   localparam int RAW_BLINK   = 3;
   localparam int RAW_TRACK   = 4;
   localparam int RAW_TMO_POL = 5;
   // safe, locked, tracking, no timeout
   localparam logic [5:0] RAW_NORMAL = 6'b110110;

   typedef struct packed {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [5:0]  raw_status;
      logic        stim;
      logic [1:0]  user;
      logic [1:0]  keys;
      logic [31:0] stamp;
      logic        last;
   } sample_type;

   // directed row: typed rows carry their bytes, first byte in the top bits
   typedef struct packed {
      sample_type  smp;
      logic        typed;
      logic [3:0]  n_bytes;
      logic [95:0] bytes;
   } row_type;

   typedef struct {
      logic [7:0] data;
      logic       eob;
   } out_word_type;

   localparam int DIRECTED_ROWS = 20;
   localparam row_type DIRECTED [DIRECTED_ROWS] = '{
      // opening sample of a trial: position taken, nothing written
      '{'{16'h0000, 16'h0000, 6'b110110, 1'b0, 2'd0, 2'd0, 32'd100, 1'b0}, 1'b1, 4'd0, 96'h0},
      // same state, run goes on
      '{'{16'h0000, 16'h0000, 6'b110110, 1'b0, 2'd0, 2'd0, 32'd101, 1'b0}, 1'b1, 4'd0, 96'h0},
      // everything changes: first run closes with a zero duration
      '{'{16'hFFFF, 16'hFFFF, 6'b111111, 1'b1, 2'd3, 2'd3, 32'd102, 1'b0}, 1'b1, 4'd3,
        96'h5000_0000_0000_0000_0000_0000},
      // final sample closes a full-change run, two-byte duration, end word
      '{'{16'hFFFF, 16'hFFFF, 6'b111111, 1'b1, 2'd3, 2'd3, 32'd1000, 1'b1}, 1'b1, 4'd10,
        96'hB381_03FF_FFFF_FF01_F800_0000},
      // final sample that is also the opening one
      '{'{16'h0005, 16'h0007, 6'b000000, 1'b0, 2'd0, 2'd0, 32'd0, 1'b1}, 1'b1, 4'd0, 96'h0},
      '{'{16'h0000, 16'h0000, 6'b000000, 1'b0, 2'd0, 2'd0, 32'hFFFF_FFFF, 1'b0},
        1'b1, 4'd0, 96'h0},
      // trial ends in the pause status: silent
      '{'{16'h0000, 16'h0000, 6'b110110, 1'b0, 2'd0, 2'd0, 32'd5, 1'b1}, 1'b1, 4'd0, 96'h0},
      // status codes, durations of every length, backwards stamps
      '{'{16'h1234, 16'h0000, 6'b110110, 1'b0, 2'd0, 2'd0, 32'd10, 1'b0}, 1'b0, 4'd0, 96'h0},
      '{'{16'h1234, 16'h0000, 6'b100000, 1'b0, 2'd0, 2'd0, 32'd11, 1'b0}, 1'b0, 4'd0, 96'h0},
      '{'{16'h1234, 16'h0000, 6'b000000, 1'b0, 2'd0, 2'd0, 32'd300, 1'b0}, 1'b0, 4'd0, 96'h0},
      '{'{16'h1234, 16'h0000, 6'b110000, 1'b0, 2'd0, 2'd0, 32'd70000, 1'b0},
        1'b0, 4'd0, 96'h0},
      '{'{16'h1234, 16'h0000, 6'b110111, 1'b0, 2'd0, 2'd0, 32'd69990, 1'b0},
        1'b0, 4'd0, 96'h0},
      '{'{16'h1234, 16'h0000, 6'b110110, 1'b0, 2'd0, 2'd0, 32'h7FFF_FFFF, 1'b0},
        1'b0, 4'd0, 96'h0},
      '{'{16'h8000, 16'h00FF, 6'b110110, 1'b0, 2'd0, 2'd0, 32'h8000_0000, 1'b0},
        1'b0, 4'd0, 96'h0},
      '{'{16'h8000, 16'h00FF, 6'b110110, 1'b1, 2'd0, 2'd0, 32'h8000_0001, 1'b0},
        1'b0, 4'd0, 96'h0},
      '{'{16'h8000, 16'h00FF, 6'b110110, 1'b1, 2'd1, 2'd2, 32'h8000_0101, 1'b0},
        1'b0, 4'd0, 96'h0},
      '{'{16'h0000, 16'h0000, 6'b111110, 1'b0, 2'd2, 2'd1, 32'h8000_0200, 1'b0},
        1'b0, 4'd0, 96'h0},
      '{'{16'h0000, 16'h0000, 6'b111110, 1'b0, 2'd2, 2'd1, 32'h8001_0300, 1'b1},
        1'b0, 4'd0, 96'h0},
      // final sample that also ends a run: two records
      '{'{16'hFFFF, 16'h0000, 6'b111111, 1'b0, 2'd0, 2'd0, 32'd0, 1'b0}, 1'b0, 4'd0, 96'h0},
      '{'{16'hFFFF, 16'h0000, 6'b010110, 1'b0, 2'd0, 2'd0, 32'hFFFF_FFFF, 1'b1},
        1'b0, 4'd0, 96'h0}
   };

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [gscr_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tlast = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [gscr_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   gscr_pkg::csr_index_type         csr_index = gscr_pkg::CSR_PAUSE;
   logic [gscr_pkg::CSR_DATA_W-1:0] csr_data = '0;

   int send_idle_pct = 12;
   int recv_idle_pct = 82;
   int error_count = 0;

   // code registers as the block should hold them
   logic [7:0] pause_code_q, blink_code_q, error_code_q, timeout_code_q;

   // open run of the current trial
   logic [15:0] seg_x, seg_y;
   logic [7:0]  seg_status, seg_flags;
   logic [3:0]  seg_mask;
   logic [31:0] seg_t0, seg_gap, prior_stamp;
   logic        seg_is_first, trial_open;

   out_word_type expected_bytes[$];
   out_word_type burst[$];

   gaze_sample_change_record_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // status byte from raw status bits, later tests win
   function automatic logic [7:0] status_byte(input logic [5:0] rs);
      logic [7:0] st;
      st = 8'h00;
      if (rs[RAW_SACCADE]) st |= gscr_pkg::STAT_SACCADE;
      if (!rs[RAW_SAFE]) st |= gscr_pkg::STAT_UNSAFE;
      if (!rs[RAW_LOCK]) st |= gscr_pkg::STAT_NOLOCK;
      if (rs[RAW_BLINK]) st = blink_code_q;
      if (!rs[RAW_TRACK]) st = error_code_q;
      if (!rs[RAW_TMO_POL]) st = timeout_code_q;
      return st;
   endfunction

   task automatic put_byte(input logic [7:0] b);
      burst.push_back('{b, 1'b0});
   endtask

   // one record for the open run
   task automatic add_record();
      logic [31:0] dt;
      logic [1:0]  dlen;
      int          nlen;
      if (seg_is_first) dt = prior_stamp - seg_t0 - 32'd1;
      else dt = prior_stamp - seg_t0 - 32'd2 + seg_gap;
      if (dt[31]) begin
         dlen = gscr_pkg::DLEN_NONE; nlen = 0;
      end else if (dt <= 32'hFF) begin
         dlen = gscr_pkg::DLEN_ONE; nlen = 1;
      end else if (dt <= 32'hFFFF) begin
         dlen = gscr_pkg::DLEN_TWO; nlen = 2;
      end else begin
         dlen = gscr_pkg::DLEN_FOUR; nlen = 4;
      end
      put_byte({dlen, seg_mask[3], seg_mask[2], 2'b00, seg_mask[1], seg_mask[0]});
      for (int i = 0; i < nlen; i++) put_byte(dt[8*i +: 8]);
      if ((seg_mask & CHG_X) != 0) begin
         put_byte(seg_x[15:8]);
         put_byte(seg_x[7:0]);
      end
      if ((seg_mask & CHG_Y) != 0) begin
         put_byte(seg_y[15:8]);
         put_byte(seg_y[7:0]);
      end
      if ((seg_mask & CHG_STAT) != 0) put_byte(seg_status);
      if ((seg_mask & CHG_FLAG) != 0) put_byte(seg_flags);
   endtask

   task automatic clear_trial();
      seg_x = '0;
      seg_y = '0;
      seg_status = pause_code_q;
      seg_flags = '0;
      seg_mask = '0;
      seg_t0 = '0;
      seg_gap = '0;
      prior_stamp = '0;
      seg_is_first = 1'b1;
      trial_open = 1'b0;
   endtask

   // bytes caused by one sample, left in burst
   task automatic encode_sample(input sample_type s);
      logic [7:0] st, fl;
      logic [3:0] chg;
      burst.delete();
      if (!trial_open) begin
         seg_x = s.pos_x;
         seg_y = s.pos_y;
         seg_status = pause_code_q;
         seg_flags = '0;
         seg_mask = CHG_STAT | ((s.pos_x != 0) ? CHG_X : 4'b0) |
                    ((s.pos_y != 0) ? CHG_Y : 4'b0);
         seg_t0 = s.stamp;
         prior_stamp = s.stamp;
         seg_gap = '0;
         seg_is_first = 1'b1;
         trial_open = 1'b1;
         if (s.last) clear_trial();
      end else begin
         st = status_byte(s.raw_status);
         fl = {s.keys, s.user, s.stim, 3'b000};
         chg = '0;
         if (s.pos_x != seg_x) chg |= CHG_X;
         if (s.pos_y != seg_y) chg |= CHG_Y;
         if (st != seg_status) chg |= CHG_STAT;
         if (fl != seg_flags) chg |= CHG_FLAG;
         if (chg != 0) begin
            add_record();
            seg_x = s.pos_x;
            seg_y = s.pos_y;
            seg_status = st;
            seg_flags = fl;
            seg_mask = chg;
            seg_gap = s.stamp - prior_stamp;
            seg_t0 = s.stamp;
            seg_is_first = 1'b0;
         end
         prior_stamp = s.stamp;
         if (s.last) begin
            if (seg_status != pause_code_q) begin
               add_record();
               put_byte(gscr_pkg::END_BYTE);
            end
            clear_trial();
         end
      end
      if (burst.size() > 0) burst[burst.size()-1].eob = 1'b1;
   endtask

   // drive one sample from a falling edge, queue its bytes on acceptance
   task automatic send_sample(input sample_type s, input logic typed, input int n_typed,
                              input logic [95:0] typed_bytes);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, s.stamp, s.keys, s.user, s.stim, s.raw_status, s.pos_y, s.pos_x};
      req_tlast <= s.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      encode_sample(s);
      if (typed) begin
         for (int i = 0; i < n_typed; i++)
            expected_bytes.push_back('{typed_bytes[95-8*i -: 8], i == n_typed - 1});
      end else begin
         foreach (burst[i]) expected_bytes.push_back(burst[i]);
      end
      @(negedge clock);
   endtask

   // drop valid, wait for every expected word, then let the block settle
   task automatic drain(input int cycles);
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (cycles) @(negedge clock);
   endtask

   task automatic write_codes(input logic [7:0] p, input logic [7:0] b,
                              input logic [7:0] e, input logic [7:0] t);
      logic [7:0]              vals [4];
      gscr_pkg::csr_index_type idx;
      vals = '{p, b, e, t};
      for (int i = 0; i < 4; i++) begin
         idx = gscr_pkg::csr_index_type'(i);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx)
            gscr_pkg::CSR_PAUSE:   pause_code_q = vals[i];
            gscr_pkg::CSR_BLINK:   blink_code_q = vals[i];
            gscr_pkg::CSR_ERROR:   error_code_q = vals[i];
            gscr_pkg::CSR_TIMEOUT: timeout_code_q = vals[i];
            default:               ;
         endcase
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_pos();
      if ($urandom_range(1) == 0) return 16'($urandom_range(0, 15));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [5:0] pick_raw();
      logic [5:0] r;
      if ($urandom_range(4) < 3) begin
         r = RAW_NORMAL;
         r[RAW_SACCADE] = 1'($urandom_range(1));
      end else begin
         r = 6'($urandom_range(0, 63));
      end
      return r;
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      s.pos_x = pick_pos();
      s.pos_y = pick_pos();
      s.raw_status = pick_raw();
      s.stim = 1'($urandom_range(1));
      s.user = 2'($urandom_range(3));
      s.keys = 2'($urandom_range(3));
      s.stamp = $urandom();
      s.last = 1'b0;
      return s;
   endfunction

   // trials of runs with random content, some noise trials mixed in
   task automatic run_random(input int count);
      sample_type  s;
      int          sent, len, r;
      logic        noisy;
      logic [31:0] t;
      sent = 0;
      while (sent < count) begin
         noisy = ($urandom_range(9) == 0);
         len = $urandom_range(1, 14);
         if (len > count - sent) len = count - sent;
         s = random_sample();
         for (int k = 0; k < len; k++) begin
            if (noisy) begin
               s = random_sample();
               s.last = ($urandom_range(3) == 0);
            end else begin
               if (k > 0) begin
                  // stamp step: mostly one to three, sometimes long or backwards
                  r = $urandom_range(99);
                  if (r < 70) s.stamp += $urandom_range(1, 3);
                  else if (r < 85) s.stamp += $urandom_range(4, 300);
                  else if (r < 93) s.stamp += $urandom_range(301, 100000);
                  else if (r < 97) s.stamp = $urandom();
                  else s.stamp -= $urandom_range(1, 50);
                  if ($urandom_range(99) < 45) begin
                     case ($urandom_range(4))
                        0: s.pos_x = pick_pos();
                        1: s.pos_y = pick_pos();
                        2: s.raw_status = pick_raw();
                        3: begin
                           s.stim = 1'($urandom_range(1));
                           s.user = 2'($urandom_range(3));
                           s.keys = 2'($urandom_range(3));
                        end
                        default: begin
                           t = s.stamp;
                           s = random_sample();
                           s.stamp = t;
                        end
                     endcase
                  end
               end
               s.last = (k == len - 1);
            end
            send_sample(s, 1'b0, 0, 96'h0);
            sent++;
         end
      end
   endtask

   // compare each output word with the oldest expectation
   always @(posedge clock) begin
      out_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            $error("out_byte: no word expected, got %h (end_of_burst %b)",
                   rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.data) begin
               $error("out_byte: expected %h, actual %h", want.data, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.eob) begin
               $error("end_of_burst: expected %b, actual %b", want.eob, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // end the run when nothing moves on any channel for too long
   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("tb_gaze_sample_change_record_encoder: errors");
      $finish;
   end

   initial begin : stimulus
      logic [7:0] code;
      pause_code_q = gscr_pkg::PAUSE_RESET;
      blink_code_q = gscr_pkg::BLINK_RESET;
      error_code_q = gscr_pkg::ERROR_RESET;
      timeout_code_q = gscr_pkg::TIMEOUT_RESET;
      clear_trial();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows under the reset codes
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_sample(DIRECTED[i].smp, DIRECTED[i].typed, int'(DIRECTED[i].n_bytes),
                     DIRECTED[i].bytes);

      // extreme codes, slow receiver
      drain(SETTLE_CYCLES);
      write_codes(8'hFF, 8'h00, 8'hFF, 8'h00);
      run_random(RANDOM_SAMPLES / 3);

      // opposite extremes, slow sender
      drain(SETTLE_CYCLES);
      send_idle_pct = 82;
      recv_idle_pct = 12;
      write_codes(8'h00, 8'hFF, 8'h00, 8'hFF);
      run_random(RANDOM_SAMPLES / 3);

      // random codes, no-track status equal to pause, full rate
      drain(SETTLE_CYCLES);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      code = 8'($urandom_range(0, 255));
      write_codes(code, 8'($urandom_range(0, 255)), code, 8'($urandom_range(0, 255)));
      run_random(RANDOM_SAMPLES - 2 * (RANDOM_SAMPLES / 3));

      drain(TAIL_CYCLES);
      if (error_count == 0)
         $display("tb_gaze_sample_change_record_encoder: clean");
      else
         $display("tb_gaze_sample_change_record_encoder: errors");
      $finish;
   end

endmodule
